FILE: rtl/epms_pkg.sv
// Shared types and constants for the streaming exact pattern matcher.
// No dependencies; every other file of the block imports this package.
package epms_pkg;

  localparam int TEXT_W        = 8;
  localparam int START_W       = 32;
  localparam int LEN_W         = 6;
  localparam int PATTERN_STORE = 32;
  localparam int PAT_IDX_W     = $clog2(PATTERN_STORE);
  localparam int PAT_REGS      = 4;
  localparam int CFG_DW        = 64;
  localparam int CFG_AW        = 6;
  localparam int REG_IDX_W     = 3;

  // Register indexes, one 64-bit slot each (byte address 8 * index).
  localparam logic [REG_IDX_W-1:0] REG_PAT_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT_C = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT_D = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 3'd4;

  typedef struct packed {
    logic [PAT_REGS-1:0][CFG_DW-1:0] pat;
    logic [LEN_W-1:0]                len;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
  } res_t;

endpackage

FILE: rtl/epms_if.sv
// Valid/ready channel interfaces for text bytes in and match results out.
// Depends on epms_pkg for the field widths.
interface epms_text_if;
  import epms_pkg::*;
  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_byte;
  logic              text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface epms_match_if;
  import epms_pkg::*;
  logic               valid;
  logic               ready;
  logic               match_found;
  logic [START_W-1:0] match_start;

  modport source (output valid, output match_found, output match_start, input ready);
  modport sink   (input valid, input match_found, input match_start, output ready);
endinterface

FILE: rtl/epms_cfg_regs.sv
// APB-style register file holding the pattern bytes and the pattern length.
// Depends on epms_pkg for register indexes and the cfg_t bundle.
module epms_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [epms_pkg::CFG_AW-1:0]   paddr,
  input  logic [epms_pkg::CFG_DW-1:0]   pwdata,
  output logic [epms_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output epms_pkg::cfg_t                cfg_o
);
  import epms_pkg::*;

  logic [PAT_REGS-1:0][CFG_DW-1:0] pat_q;
  logic [LEN_W-1:0]                len_q;
  logic [REG_IDX_W-1:0]            reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[CFG_AW-1:CFG_AW-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAT_A:   pat_q[0] <= pwdata;
        REG_PAT_B:   pat_q[1] <= pwdata;
        REG_PAT_C:   pat_q[2] <= pwdata;
        REG_PAT_D:   pat_q[3] <= pwdata;
        REG_PAT_LEN: len_q    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAT_A:   prdata = pat_q[0];
      REG_PAT_B:   prdata = pat_q[1];
      REG_PAT_C:   prdata = pat_q[2];
      REG_PAT_D:   prdata = pat_q[3];
      REG_PAT_LEN: prdata = CFG_DW'(len_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.pat = pat_q;
  assign cfg_o.len = len_q;

endmodule

FILE: rtl/epms_cell.sv
// One window cell: holds one text byte, passes it to its right neighbor and
// folds its byte compare into the running match chain. Depends on epms_pkg.
module epms_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  epms_pkg::cell_ctrl_t        ctrl_i,
  input  logic [epms_pkg::TEXT_W-1:0] byte_i,
  input  logic [epms_pkg::TEXT_W-1:0] pat_byte_i,
  input  logic                        use_i,
  input  logic                        hit_i,
  output logic [epms_pkg::TEXT_W-1:0] byte_o,
  output logic                        hit_o
);
  import epms_pkg::*;

  logic [TEXT_W-1:0] byte_q;
  logic [TEXT_W-1:0] byte_d;

  // Compare the byte that is about to enter, so the result matches the
  // window that ends at the incoming byte.
  assign hit_o = hit_i && (!use_i || (byte_i == pat_byte_i));

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? '0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/exact_pattern_match_stream.sv
// Streaming exact pattern matcher: one text byte in, one match result out.
// Each result is registered, in the output register or in the skid on an output stall.
// Throughput: one byte per cycle unless the skid is full, set by the single compare pass.
// Output stage is an output register plus a skid: on an output stall it takes one more
// transaction, then holds the input until the skid drains.
// Reset clears the window, the position count and the pattern bytes; length resets to 1.
module exact_pattern_match_stream #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  epms_text_if.sink                   text_i,
  epms_match_if.source                match_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [epms_pkg::CFG_AW-1:0] paddr,
  input  logic [epms_pkg::CFG_DW-1:0] pwdata,
  output logic [epms_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import epms_pkg::*;

  // Longest pattern that both the window and the pattern registers can hold.
  localparam int CAP = (MAX_PATTERN < PATTERN_STORE) ? MAX_PATTERN : PATTERN_STORE;

  cfg_t cfg;

  epms_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective length: zero acts as one, anything past CAP acts as CAP.
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] len_m1;

  always_comb begin
    len_eff = cfg.len;
    if (cfg.len == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg.len > LEN_W'(CAP)) begin
      len_eff = LEN_W'(CAP);
    end
  end

  assign len_m1 = len_eff - LEN_W'(1);

  // Pattern bytes in text order, byte 0 in the lowest bits of register A.
  logic [PATTERN_STORE-1:0][TEXT_W-1:0] pat_bytes;
  assign pat_bytes = cfg.pat;

  // Handshake and output staging.
  logic acc;
  logic out_fire;
  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q, res_new;

  assign text_i.ready = !skid_vld_q;
  assign acc          = text_i.valid && text_i.ready;
  assign out_fire     = out_vld_q && match_o.ready;

  // Cell chain: cell k holds window byte k, newest at cell 0.
  cell_ctrl_t                     ctrl;
  logic [TEXT_W-1:0]              win [MAX_PATTERN];
  logic [TEXT_W-1:0]              feed [MAX_PATTERN];
  logic                           hit [MAX_PATTERN+1];

  assign ctrl.shift = acc;
  assign ctrl.clear = text_i.text_last;
  assign hit[0]     = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W:0]       idx_full;
    logic                 use_k;

    // Cell k lines up against pattern byte (len - 1 - k) when k < len.
    assign idx_full = {1'b0, len_m1} - (LEN_W+1)'(k);
    assign use_k    = ((LEN_W+1)'(k) < {1'b0, len_eff});

    if (k == 0) begin : g_head
      assign feed[k] = text_i.text_byte;
    end else begin : g_body
      assign feed[k] = win[k-1];
    end

    epms_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (feed[k]),
      .pat_byte_i (pat_bytes[idx_full[PAT_IDX_W-1:0]]),
      .use_i      (use_k),
      .hit_i      (hit[k]),
      .byte_o     (win[k]),
      .hit_o      (hit[k+1])
    );
  end

  // Position of the current byte in its text; saturates at all ones.
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] len_m1_pos;
  logic                     window_full;

  assign len_m1_pos  = POSITION_BITS'(len_m1);
  assign window_full = (pos_q >= len_m1_pos);

  assign res_new.found = hit[MAX_PATTERN] && window_full;
  assign res_new.start = res_new.found ? START_W'(pos_q - len_m1_pos) : '0;

  always_comb begin
    pos_d = pos_q;
    if (acc) begin
      if (text_i.text_last) begin
        pos_d = '0;
      end else if (pos_q != '1) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Output register with skid: drain the skid first, otherwise load the new
  // transaction straight into the output, and park it in the skid on a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= acc;
      end
    end else if (acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res_new;
      end
    end else if (acc) begin
      skid_q <= res_new;
    end
  end

  assign match_o.valid       = out_vld_q;
  assign match_o.match_found = out_q.found;
  assign match_o.match_start = out_q.start;

  // A parked transaction always has one ahead of it in the output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a transaction while output register is empty");

  // The parked transaction never changes while it waits.
  a_skid_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> (!skid_vld_q || $stable(skid_q)))
    else $error("skid contents changed while parked");

  // A last byte restarts the position count.
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && text_i.text_last) |=> (pos_q == '0))
    else $error("position not cleared after last byte");

  // Otherwise the position advances by one until it saturates.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !text_i.text_last && (pos_q != '1)) |=>
      (pos_q == $past(pos_q) + POSITION_BITS'(1)))
    else $error("position did not advance by one");

endmodule

FILE: bench/exact_pattern_match_stream_test.sv
// Self-checking bench for exact_pattern_match_stream: text byte transactions in,
// one match result out per byte. Depends on epms_pkg and the epms_if channels.
module exact_pattern_match_stream_test;
  import epms_pkg::*;

  // Longest pattern the block honors with the default MAX_PATTERN.
  localparam int unsigned MAX_PAT = 32;
  // Cycles with no transaction anywhere before the run is called hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Length of the long receiver hold-off that backs the pipe up.
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [TEXT_W-1:0] text_byte;
    logic              text_last;
    bit                drain;     // hold this byte until every result is back
  } text_item_t;

  logic clk_i;
  logic rst_ni;

  epms_text_if  text_bus ();
  epms_match_if match_bus ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  exact_pattern_match_stream uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_bus),
    .match_o (match_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench-side copy of the matcher: pattern registers, window and position.
  logic [CFG_DW-1:0] pat_regs [PAT_REGS];
  logic [LEN_W-1:0]  pat_len;
  logic [7:0]        window_bytes [MAX_PAT];
  logic [START_W-1:0] seen_count;

  text_item_t  text_pending [$];
  res_t        match_expected [$];

  bit          text_took;
  bit          match_took;
  bit          idle_on;
  int unsigned issued;
  int unsigned accepted;
  int unsigned errors;
  int unsigned quiet;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned hold_left;
  logic [7:0]  sym_lo;
  logic [7:0]  sym_hi;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Length code as the block uses it: zero acts as one, anything long is capped.
  function automatic int unsigned eff_len();
    int unsigned n;
    n = pat_len;
    if (n == 0) n = 1;
    if (n > MAX_PAT) n = MAX_PAT;
    return n;
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned i);
    return pat_regs[i >> 3][(i & 7) * 8 +: 8];
  endfunction

  function automatic logic [7:0] pick_symbol();
    return ($urandom_range(0, 1) != 0) ? sym_hi : sym_lo;
  endfunction

  // Shift one byte into the window and report whether the window ending at it
  // matches. Position saturates; a last byte clears position and window.
  function automatic res_t scan_text_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    logic        hit;
    res_t        r;
    n = eff_len();
    for (int k = MAX_PAT - 1; k > 0; k--) window_bytes[k] = window_bytes[k - 1];
    window_bytes[0] = b;
    hit = (seen_count >= n - 1);
    if (hit) begin
      for (int k = 0; k < n; k++) begin
        if (window_bytes[k] != pat_byte(n - 1 - k)) hit = 1'b0;
      end
    end
    r.found = hit;
    r.start = hit ? seen_count - START_W'(n - 1) : '0;
    if (seen_count != '1) seen_count++;
    if (last) begin
      seen_count = '0;
      for (int k = 0; k < MAX_PAT; k++) window_bytes[k] = 8'h00;
    end
    return r;
  endfunction

  // Sender: present the front of the queue, advance on acceptance, then idle
  // for the drawn gap. A byte marked drain waits for the result side to empty.
  always @(negedge clk_i) begin
    logic offer;
    if (!rst_ni) begin
      text_bus.valid <= 1'b0;
    end else begin
      offer = text_bus.valid;
      if (offer && text_took) begin
        void'(text_pending.pop_front());
        offer = 1'b0;
        send_gap = idle_on ? $urandom_range(0, 10) : 0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (text_pending.size() != 0 &&
                     !(text_pending[0].drain && match_expected.size() != 0)) begin
          offer = 1'b1;
          text_bus.text_byte <= text_pending[0].text_byte;
          text_bus.text_last <= text_pending[0].text_last;
        end
      end
      text_bus.valid <= offer;
    end
  end

  // Receiver: stall a drawn number of cycles after each result, and serve any
  // requested long hold-off first so the block fills and stalls its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      match_bus.ready <= 1'b0;
    end else begin
      if (match_took) recv_stall = idle_on ? $urandom_range(0, 10) : 0;
      if (hold_asked != hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        match_bus.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        match_bus.ready <= 1'b0;
      end else begin
        match_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation, then
  // predict the result of any byte accepted at this edge. Also the watchdog.
  always @(posedge clk_i) begin
    res_t want;
    bit   apb_took;
    if (rst_ni) begin
      text_took  = text_bus.valid && text_bus.ready;
      match_took = match_bus.valid && match_bus.ready;
      apb_took   = psel && penable && pwrite && pready;
      if (match_took) begin
        if (match_expected.size() == 0) begin
          $display("%0t: unexpected result found=%0b start=%0d", $time,
                   match_bus.match_found, match_bus.match_start);
          errors++;
        end else begin
          want = match_expected.pop_front();
          if (want.found !== match_bus.match_found) begin
            $display("%0t: match_found expected %0b actual %0b", $time,
                     want.found, match_bus.match_found);
            errors++;
          end
          if (want.start !== match_bus.match_start) begin
            $display("%0t: match_start expected %0d actual %0d", $time,
                     want.start, match_bus.match_start);
            errors++;
          end
        end
      end
      if (text_took) begin
        match_expected.push_back(scan_text_byte(text_bus.text_byte, text_bus.text_last));
        accepted++;
      end
      if (text_took || match_took || apb_took) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // APB write: setup phase, access phase, then mirror the value once it lands.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_PAT_LEN) pat_len = val[LEN_W-1:0];
    else pat_regs[idx[1:0]] = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last, input bit drain);
    text_item_t it;
    it.text_byte = b;
    it.text_last = last;
    it.drain     = drain;
    text_pending.push_back(it);
    issued++;
  endtask

  // Wait until every byte is taken and every result checked, then let the
  // pipe settle before touching registers.
  task automatic settle();
    while (accepted != issued || match_expected.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Program all four pattern words and the length. Pattern bytes come from a
  // two-symbol alphabet so matches and overlaps are frequent, or are fully
  // random words. Upper bits of the length word are junk the block drops.
  task automatic load_pattern(input logic [LEN_W-1:0] len_code, input bit wide_random);
    logic [CFG_DW-1:0] word;
    for (int r = 0; r < PAT_REGS; r++) begin
      if (wide_random) begin
        word = {$urandom, $urandom};
      end else begin
        for (int j = 0; j < 8; j++) word[j * 8 +: 8] = pick_symbol();
      end
      write_reg(REG_PAT_A + REG_IDX_W'(r), word);
    end
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = len_code;
    write_reg(REG_PAT_LEN, word);
  endtask

  // Random text: mostly whole copies of the pattern, some with one byte
  // spoiled, mixed with runs of alphabet symbols and raw noise.
  task automatic fill_text(input int unsigned count, input bit pause_mid);
    logic [7:0]  chunk [$];
    int unsigned n;
    int unsigned made;
    int unsigned kind;
    int unsigned bad;
    n    = eff_len();
    made = 0;
    while (made < count) begin
      chunk.delete();
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < n; i++) chunk.push_back(i == bad ? pick_symbol() : pat_byte(i));
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 4)) chunk.push_back(pick_symbol());
      end else begin
        repeat ($urandom_range(1, 3)) chunk.push_back(8'($urandom_range(0, 255)));
      end
      foreach (chunk[i]) begin
        add_byte(chunk[i], $urandom_range(0, 59) == 0, pause_mid && made == count / 2);
        made++;
      end
    end
  endtask

  initial begin
    int unsigned lens [10];
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    text_bus.valid    = 1'b0;
    text_bus.text_byte = '0;
    text_bus.text_last = 1'b0;
    match_bus.ready   = 1'b0;
    for (int r = 0; r < PAT_REGS; r++) pat_regs[r] = '0;
    pat_len    = LEN_W'(1);
    seen_count = '0;
    for (int k = 0; k < MAX_PAT; k++) window_bytes[k] = 8'h00;
    idle_on = 1'b1;
    sym_lo  = 8'h00;
    sym_hi  = 8'hFF;
    lens    = '{1, 2, 32, 5, 63, 0, 3, 17, 40, 8};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset pattern: length one, byte zero. Field extremes and a text break.
    @(posedge clk_i);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    settle();

    // Length code zero acts as one.
    write_reg(REG_PAT_A, 64'hFF);
    write_reg(REG_PAT_LEN, 64'd0);
    @(posedge clk_i);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0);
    settle();

    // Pattern "aba": no match before the window fills, overlapping hits,
    // and a last byte that cuts an occurrence in two.
    write_reg(REG_PAT_A, 64'h616261);
    write_reg(REG_PAT_LEN, 64'd3);
    @(posedge clk_i);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b1, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    settle();

    // Random phases over a spread of lengths, including the capped ones.
    for (int ph = 0; ph < 10; ph++) begin
      sym_lo = 8'($urandom_range(0, 255));
      sym_hi = 8'($urandom_range(0, 255));
      load_pattern(LEN_W'(ph < 8 ? lens[ph] : $urandom_range(1, 12)), ph == 2 || ph == 7);
      @(posedge clk_i);
      idle_on = (ph % 3 != 1);
      if (ph == 3) hold_asked++;
      fill_text(100, ph == 6);
      settle();
    end

    if (match_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, match_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
